### rtl/frame_timestamp_matcher_macros.svh
// Assertion helpers for the frame timestamp matcher.
`ifndef FRAME_TIMESTAMP_MATCHER_MACROS_SVH
`define FRAME_TIMESTAMP_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

`define FTM_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("frame_timestamp_matcher: check failed");

`define FTM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("frame_timestamp_matcher: sequence check failed");

`else

`define FTM_ASSERT(lbl, clk_s, rst_s, prop)

`define FTM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### rtl/ftm_pkg.sv
package ftm_pkg;

    localparam int CHANNELS    = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOTS       = CHANNELS * QUEUE_DEPTH;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int POSX_W   = POS_W + 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] FIRST_NUMBER = 32'd1;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_MATCH    = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } scan_state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_EMPTY,
        RES_WRITE,
        RES_ENTRY
    } res_sel_t;

    typedef struct packed {
        logic [31:0]        number;
        logic [63:0]        stamp;
        logic signed [63:0] capture;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] addr;
    } ram_req_t;

    typedef struct packed {
        res_sel_t   sel;
        logic       exact;
        logic       emit;
        logic [1:0] channel;
    } res_ctl_t;

    // head + offset stays below twice the depth, so one subtract wraps it
    function automatic logic [POS_W-1:0] wrap_pos(input logic [POSX_W-1:0] p);
        logic [POSX_W-1:0] r;
        if (p >= POSX_W'(QUEUE_DEPTH))
            r = p - POSX_W'(QUEUE_DEPTH);
        else
            r = p;
        return r[POS_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_IDX_W-1:0] ch,
                                                  input logic [POS_W-1:0] pos);
        return SLOT_W'(SLOT_W'(ch) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(pos));
    endfunction

endpackage

### rtl/frame_timestamp_matcher.sv
// Frame timestamp matcher: per-channel queues of pending source frames.
// Command channel: an item (op, channel, timestamp, capture_ms) is taken on
// a rising edge with start high and busy low. busy stays high while the item
// is worked on.
// Result channel: valid is high for exactly one cycle with the result on
// found, exact, frame_number, source_stamp, capture_time, channel_out and
// encoded_stamp. The receiver cannot stall; each result must be taken then.
// Flow: register and empty-queue match give their result from the execute
// state through the output register. A match on a non-empty queue reads the
// entries oldest first and stops at the first hit or after the last entry;
// the entry memory's single port reads one slot per cycle, which sets the
// scan length. Clear and ignored items hold busy for 1 cycle and give no
// result. A new item may be taken in the cycle the previous result is shown.
// Reset: all queues empty and the frame counter at 1, applied at once; the
// entry memory is not cleared, only live slots are ever read.
`include "frame_timestamp_matcher_macros.svh"

module frame_timestamp_matcher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [1:0]         channel,
    input  logic [63:0]        timestamp,
    input  logic signed [63:0] capture_ms,
    output logic               valid,
    output logic               found,
    output logic               exact,
    output logic [31:0]        frame_number,
    output logic [63:0]        source_stamp,
    output logic signed [63:0] capture_time,
    output logic [1:0]         channel_out,
    output logic [63:0]        encoded_stamp
);

    import ftm_pkg::*;

    ram_req_t     ram_req;
    entry_t       ram_wdata;
    entry_t       ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;
    res_ctl_t     res_ctl;
    logic [63:0]  item_stamp;

    logic               valid_reg;
    logic               found_reg;
    logic               exact_reg;
    logic [31:0]        number_reg;
    logic [63:0]        stamp_reg;
    logic signed [63:0] capture_reg;
    logic [1:0]         channel_reg;
    logic [63:0]        encoded_reg;

    ftm_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .channel    (channel),
        .timestamp  (timestamp),
        .capture_ms (capture_ms),
        .busy       (busy),
        .ram_req    (ram_req),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .res_ctl    (res_ctl),
        .item_stamp (item_stamp)
    );

    ftm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_wdata),
        .rdata (ram_rbits)
    );

    assign ram_rdata = ram_rbits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= res_ctl.emit;
    end

    always_ff @(posedge clk)
    begin
        case (res_ctl.sel)
            RES_EMPTY:
            begin
                found_reg   <= 1'b0;
                exact_reg   <= 1'b0;
                number_reg  <= '0;
                stamp_reg   <= '0;
                capture_reg <= '0;
                channel_reg <= '0;
                encoded_reg <= '0;
            end
            RES_WRITE:
            begin
                found_reg   <= 1'b1;
                exact_reg   <= 1'b0;
                number_reg  <= ram_wdata.number;
                stamp_reg   <= ram_wdata.stamp;
                capture_reg <= ram_wdata.capture;
                channel_reg <= res_ctl.channel;
                encoded_reg <= '0;
            end
            RES_ENTRY:
            begin
                found_reg   <= 1'b1;
                exact_reg   <= res_ctl.exact;
                number_reg  <= ram_rdata.number;
                stamp_reg   <= ram_rdata.stamp;
                capture_reg <= ram_rdata.capture;
                channel_reg <= res_ctl.channel;
                encoded_reg <= item_stamp;
            end
            default:
            begin
            end
        endcase
    end

    assign valid         = valid_reg;
    assign found         = found_reg;
    assign exact         = exact_reg;
    assign frame_number  = number_reg;
    assign source_stamp  = stamp_reg;
    assign capture_time  = capture_reg;
    assign channel_out   = channel_reg;
    assign encoded_stamp = encoded_reg;

    `FTM_ASSERT(a_strobe_when_idle, clk, rst_n, !valid_reg || !busy)

endmodule

### rtl/ftm_ram.sv
module ftm_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ftm_scan.sv
`include "frame_timestamp_matcher_macros.svh"

module ftm_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  logic [1:0]         channel,
    input  logic [63:0]        timestamp,
    input  logic signed [63:0] capture_ms,
    output logic               busy,
    output ftm_pkg::ram_req_t  ram_req,
    output ftm_pkg::entry_t    ram_wdata,
    input  ftm_pkg::entry_t    ram_rdata,
    output ftm_pkg::res_ctl_t  res_ctl,
    output logic [63:0]        item_stamp
);

    import ftm_pkg::*;

    scan_state_t        state_reg, state_next;
    logic [POS_W-1:0]   head_reg  [CHANNELS];
    logic [POS_W-1:0]   head_next [CHANNELS];
    logic [CNT_W-1:0]   count_reg  [CHANNELS];
    logic [CNT_W-1:0]   count_next [CHANNELS];
    logic [31:0]        number_reg, number_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   cmp_reg, cmp_next;
    logic               rvalid_reg, rvalid_next;

    // item beat, captured on accept
    logic [1:0]         op_reg;
    logic [1:0]         ch_reg;
    logic [63:0]        ts_reg;
    logic signed [63:0] cap_reg;

    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok;
    logic [POS_W-1:0]    head_cur;
    logic [CNT_W-1:0]    cnt_cur;
    logic [POS_W-1:0]    tail_pos;
    logic [POS_W-1:0]    issue_pos;
    logic                hit;
    logic                last;

    assign busy       = (state_reg != ST_IDLE);
    assign item_stamp = ts_reg;

    assign ch_idx    = CH_IDX_W'(ch_reg);
    assign ch_ok     = (32'(ch_reg) < 32'(CHANNELS));
    assign head_cur  = head_reg[ch_idx];
    assign cnt_cur   = count_reg[ch_idx];
    assign tail_pos  = wrap_pos(POSX_W'(head_cur) + POSX_W'(cnt_cur));
    assign issue_pos = wrap_pos(POSX_W'(head_cur) + POSX_W'(issue_reg));
    assign hit       = rvalid_reg && (ram_rdata.stamp == ts_reg);
    assign last      = rvalid_reg && (CNT_W'(cmp_reg + 1'b1) == cnt_cur);

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= op;
            ch_reg  <= channel;
            ts_reg  <= timestamp;
            cap_reg <= capture_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            number_reg <= FIRST_NUMBER;
            issue_reg  <= '0;
            cmp_reg    <= '0;
            rvalid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            number_reg <= number_next;
            issue_reg  <= issue_next;
            cmp_reg    <= cmp_next;
            rvalid_reg <= rvalid_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        number_next = number_reg;
        issue_next  = issue_reg;
        cmp_next    = cmp_reg;
        rvalid_next = 1'b0;
        ram_req     = '{we: 1'b0, re: 1'b0, addr: slot_of(ch_idx, issue_pos)};
        ram_wdata   = '{number: number_reg, stamp: ts_reg, capture: cap_reg};
        res_ctl     = '{sel: RES_NONE, exact: 1'b0, emit: 1'b0, channel: ch_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            head_next[c]  = '0;
                            count_next[c] = '0;
                        end
                        number_next = FIRST_NUMBER;
                    end

                    OP_REGISTER:
                    begin
                        if (ch_ok)
                        begin
                            ram_req.we = 1'b1;
                            if (cnt_cur < CNT_W'(QUEUE_DEPTH))
                            begin
                                ram_req.addr       = slot_of(ch_idx, tail_pos);
                                count_next[ch_idx] = CNT_W'(cnt_cur + 1'b1);
                            end
                            else
                            begin
                                // full: overwrite the oldest slot
                                ram_req.addr      = slot_of(ch_idx, head_cur);
                                head_next[ch_idx] =
                                    wrap_pos(POSX_W'(head_cur) + POSX_W'(1));
                            end
                            number_next = number_reg + 32'd1;
                            res_ctl.sel  = RES_WRITE;
                            res_ctl.emit = 1'b1;
                        end
                    end

                    OP_MATCH:
                    begin
                        if (ch_ok)
                        begin
                            if (cnt_cur == '0)
                            begin
                                res_ctl.sel     = RES_EMPTY;
                                res_ctl.emit    = 1'b1;
                                res_ctl.channel = 2'd0;
                            end
                            else
                            begin
                                issue_next = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            ST_SCAN:
            begin
                // reads are issued back to back; each compare comes in the cycle after its read
                if (rvalid_reg && (hit || cmp_reg == '0))
                begin
                    res_ctl.sel   = RES_ENTRY;
                    res_ctl.exact = hit;
                end
                if (hit)
                begin
                    res_ctl.emit       = 1'b1;
                    head_next[ch_idx]  =
                        wrap_pos(POSX_W'(head_cur) + POSX_W'(cmp_reg) + POSX_W'(1));
                    count_next[ch_idx] = CNT_W'(cnt_cur - cmp_reg - 1'b1);
                    state_next         = ST_IDLE;
                end
                else if (last)
                begin
                    // no match: the oldest beat, held since the first compare
                    res_ctl.emit       = 1'b1;
                    head_next[ch_idx]  = wrap_pos(POSX_W'(head_cur) + POSX_W'(1));
                    count_next[ch_idx] = CNT_W'(cnt_cur - 1'b1);
                    state_next         = ST_IDLE;
                end
                else if (issue_reg < cnt_cur)
                begin
                    ram_req.re  = 1'b1;
                    issue_next  = CNT_W'(issue_reg + 1'b1);
                    cmp_next    = issue_reg;
                    rvalid_next = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FTM_ASSERT(a_no_rw_same_cycle, clk, rst_n, !(ram_req.we && ram_req.re))
    `FTM_ASSERT(a_cmp_in_range, clk, rst_n, !rvalid_reg || (cmp_reg < cnt_cur))
    `FTM_ASSERT(a_count_bounded, clk, rst_n, cnt_cur <= CNT_W'(QUEUE_DEPTH))
    `FTM_ASSERT_NEXT(a_emit_ends_item, clk, rst_n, res_ctl.emit, state_reg == ST_IDLE)
    `FTM_ASSERT(a_read_only_in_scan, clk, rst_n, !ram_req.re || (state_reg == ST_SCAN))

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ftm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_PCT    = 11;
    localparam int         RANDOM_CMDS = 1000;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         ch;
        logic [63:0]        stamp;
        logic signed [63:0] capture;
    } frame_cmd_t;

    typedef struct packed {
        logic               found;
        logic               exact;
        logic [31:0]        number;
        logic [63:0]        src_stamp;
        logic signed [63:0] capture;
        logic [1:0]         ch;
        logic [63:0]        enc_stamp;
    } frame_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         op = '0;
    logic [1:0]         channel = '0;
    logic [63:0]        timestamp = '0;
    logic signed [63:0] capture_ms = '0;
    logic               busy;
    logic               valid;
    logic               found;
    logic               exact;
    logic [31:0]        frame_number;
    logic [63:0]        source_stamp;
    logic signed [63:0] capture_time;
    logic [1:0]         channel_out;
    logic [63:0]        encoded_stamp;

    frame_timestamp_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .channel      (channel),
        .timestamp    (timestamp),
        .capture_ms   (capture_ms),
        .valid        (valid),
        .found        (found),
        .exact        (exact),
        .frame_number (frame_number),
        .source_stamp (source_stamp),
        .capture_time (capture_time),
        .channel_out  (channel_out),
        .encoded_stamp(encoded_stamp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // shadow copy of the per-channel frame queues
    entry_t               frame_store [SLOTS];
    logic [POS_W-1:0]     q_head      [CHANNELS];
    logic [CNT_W-1:0]     q_count     [CHANNELS];
    logic [31:0]          frame_ctr = FIRST_NUMBER;

    frame_cmd_t    cmd_backlog[$];
    frame_result_t pending_results[$];

    int total_cmds  = 0;
    int beats_taken = 0;
    int mismatches  = 0;
    int unexpected  = 0;
    int stall_cnt   = 0;

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            q_head[c]  = '0;
            q_count[c] = '0;
        end
    end

    task automatic advance_matcher(input frame_cmd_t c);
        int            h;
        int            n;
        int            s;
        int            hit;
        frame_result_t r;
        r   = '0;
        h   = int'(q_head[c.ch]);
        n   = int'(q_count[c.ch]);
        hit = -1;
        case (c.op)
            OP_CLEAR:
            begin
                for (int k = 0; k < CHANNELS; k++)
                begin
                    q_head[k]  = '0;
                    q_count[k] = '0;
                end
                frame_ctr = FIRST_NUMBER;
            end
            OP_REGISTER:
            begin
                if (n < QUEUE_DEPTH)
                begin
                    s = c.ch * QUEUE_DEPTH + (h + n) % QUEUE_DEPTH;
                    q_count[c.ch] = CNT_W'(n + 1);
                end
                else
                begin
                    // full: overwrite the oldest
                    s = c.ch * QUEUE_DEPTH + h;
                    q_head[c.ch] = POS_W'((h + 1) % QUEUE_DEPTH);
                end
                frame_store[s].number  = frame_ctr;
                frame_store[s].stamp   = c.stamp;
                frame_store[s].capture = c.capture;
                frame_ctr = frame_ctr + 32'd1;
                r.found     = 1'b1;
                r.number    = frame_store[s].number;
                r.src_stamp = frame_store[s].stamp;
                r.capture   = frame_store[s].capture;
                r.ch        = c.ch;
                pending_results = {pending_results, r};
            end
            OP_MATCH:
            begin
                if (n != 0)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        s = c.ch * QUEUE_DEPTH + (h + i) % QUEUE_DEPTH;
                        if (hit < 0 && frame_store[s].stamp == c.stamp)
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        s = c.ch * QUEUE_DEPTH + (h + hit) % QUEUE_DEPTH;
                        r.exact = 1'b1;
                        q_head[c.ch]  = POS_W'((h + hit + 1) % QUEUE_DEPTH);
                        q_count[c.ch] = CNT_W'(n - hit - 1);
                    end
                    else
                    begin
                        // miss pops the oldest
                        s = c.ch * QUEUE_DEPTH + h;
                        q_head[c.ch]  = POS_W'((h + 1) % QUEUE_DEPTH);
                        q_count[c.ch] = CNT_W'(n - 1);
                    end
                    r.found     = 1'b1;
                    r.number    = frame_store[s].number;
                    r.src_stamp = frame_store[s].stamp;
                    r.capture   = frame_store[s].capture;
                    r.ch        = c.ch;
                    r.enc_stamp = c.stamp;
                end
                pending_results = {pending_results, r};
            end
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [1:0] o, input logic [1:0] ch,
                             input logic [63:0] ts, input logic signed [63:0] cap);
        frame_cmd_t c;
        c.op      = o;
        c.ch      = ch;
        c.stamp   = ts;
        c.capture = cap;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // driver
    frame_cmd_t cur_cmd;
    int         idle_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                advance_matcher(cur_cmd);
                beats_taken++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    // long stretch with no idle gaps in the middle of the random part
                    if (!(beats_taken >= 400 && beats_taken < 650) &&
                        $urandom_range(99) < IDLE_PCT)
                    begin
                        idle_left = $urandom_range(4);
                        start <= 1'b0;
                    end
                    else
                    begin
                        cur_cmd = cmd_backlog[0];
                        cmd_backlog.delete(0);
                        op         <= cur_cmd.op;
                        channel    <= cur_cmd.ch;
                        timestamp  <= cur_cmd.stamp;
                        capture_ms <= cur_cmd.capture;
                        start      <= 1'b1;
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (rst_n && valid)
        begin
            got.found     = found;
            got.exact     = exact;
            got.number    = frame_number;
            got.src_stamp = source_stamp;
            got.capture   = capture_time;
            got.ch        = channel_out;
            got.enc_stamp = encoded_stamp;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result beat: found=%0b exact=%0b num=%0d ch=%0d",
                             got.found, got.exact, got.number, got.ch);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.found !== want.found || got.exact !== want.exact ||
                    got.number !== want.number || got.src_stamp !== want.src_stamp ||
                    got.capture !== want.capture || got.ch !== want.ch ||
                    got.enc_stamp !== want.enc_stamp)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                    begin
                        $display("mismatch exp: found=%0b exact=%0b num=%0d src=%h cap=%0d ch=%0d enc=%h",
                                 want.found, want.exact, want.number, want.src_stamp,
                                 want.capture, want.ch, want.enc_stamp);
                        $display("         got: found=%0b exact=%0b num=%0d src=%h cap=%0d ch=%0d enc=%h",
                                 got.found, got.exact, got.number, got.src_stamp,
                                 got.capture, got.ch, got.enc_stamp);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || valid)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("FAIL frame_timestamp_matcher");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0]        stamp_pool [16];
        logic [63:0]        ts;
        logic signed [63:0] cap;
        logic [1:0]         ch;
        int                 r;
        int                 counted;

        // channel 3: extremes, exact hit on the second entry, then empty match
        queue_cmd(OP_REGISTER, 2'd3, 64'd0, 64'sh8000_0000_0000_0000);
        queue_cmd(OP_REGISTER, 2'd3, '1, 64'sh7FFF_FFFF_FFFF_FFFF);
        queue_cmd(OP_MATCH, 2'd3, '1, 64'sd0);
        queue_cmd(OP_MATCH, 2'd3, 64'd0, 64'sd0);
        // channel 1: overfill drops the oldest
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            queue_cmd(OP_REGISTER, 2'd1, 64'(i), 64'(-i));
        queue_cmd(OP_MATCH, 2'd1, 64'd5, '1);
        queue_cmd(OP_MATCH, 2'd1, 64'd12345, 64'sd0);
        queue_cmd(OP_REGISTER, 2'd2, 64'h8000_0000_0000_0000, -64'sd1);
        queue_cmd(OP_MATCH, 2'd2, 64'h7FFF_FFFF_FFFF_FFFF, 64'sd0);
        queue_cmd(OP_UNUSED, 2'd1, '1, '1);
        queue_cmd(OP_CLEAR, 2'd0, '1, '1);
        queue_cmd(OP_MATCH, 2'd1, 64'd8, 64'sd0);
        queue_cmd(OP_REGISTER, 2'd0, 64'h0123_4567_89AB_CDEF, 64'sd42);

        for (int i = 0; i < 16; i++)
            stamp_pool[i] = {$urandom, $urandom};
        stamp_pool[0] = '0;
        stamp_pool[1] = '1;

        // mostly register/match on a shared stamp pool so hits are common
        counted = 0;
        while (counted < RANDOM_CMDS)
        begin
            r   = $urandom_range(99);
            ch  = 2'($urandom_range(3));
            ts  = $urandom_range(1) ? stamp_pool[$urandom_range(15)] : {$urandom, $urandom};
            cap = {$urandom, $urandom};
            if ($urandom_range(19) == 0)
                cap = $urandom_range(1) ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            if (r < 3)
                queue_cmd(OP_UNUSED, ch, ts, cap);
            else
            begin
                if (r < 6)
                    queue_cmd(OP_CLEAR, ch, ts, cap);
                else if (r < 55)
                    queue_cmd(OP_REGISTER, ch, ts, cap);
                else
                    queue_cmd(OP_MATCH, ch, ts, cap);
                counted++;
            end
        end
        total_cmds = cmd_backlog.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken < total_cmds)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
            $display("PASS frame_timestamp_matcher");
        else
            $display("FAIL frame_timestamp_matcher");
        $finish;
    end

endmodule
